// ===== rtl/psq_pkg.sv =====
// ============================================================================
// psq_pkg
// Shared types and constants of the publish request sequencer.
// ============================================================================
package psq_pkg;

    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned TOPIC_W   = 8;
    localparam int unsigned LEN_W     = 10;
    localparam int unsigned MSG_W     = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LEVEL_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROMPT_TIMEOUT = 3'd0,
        CFG_SEND_TIMEOUT   = 3'd1,
        CFG_OK_TIMEOUT     = 3'd2,
        CFG_TOPIC_LIMIT    = 3'd3,
        CFG_PAYLOAD_LIMIT  = 3'd4
    } cfg_index_t;

    localparam logic [TIMEOUT_W-1:0] PROMPT_TIMEOUT_RST = 16'd1000;
    localparam logic [TIMEOUT_W-1:0] SEND_TIMEOUT_RST   = 16'd100;
    localparam logic [TIMEOUT_W-1:0] OK_TIMEOUT_RST     = 16'd1000;
    localparam logic [TOPIC_W-1:0]   TOPIC_LIMIT_RST    = 8'd80;
    localparam logic [LEN_W-1:0]     PAYLOAD_LIMIT_RST  = 10'd640;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PROMPT = 2'd1,
        PH_SENT   = 2'd2,
        PH_OK     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE           = 3'd0,
        ACT_PUBLISH        = 3'd1,
        ACT_WRITE_PAYLOAD  = 3'd2,
        ACT_SUCCESS        = 3'd3,
        ACT_PROMPT_TIMEOUT = 3'd4,
        ACT_SEND_TIMEOUT   = 3'd5,
        ACT_ERROR          = 3'd6,
        ACT_WRITE_FAIL     = 3'd7
    } action_t;

    typedef struct packed {
        logic enq_req;
        logic pop;
    } psq_qctl_t;

    typedef struct packed {
        logic empty;
        logic accepted;
    } psq_qstat_t;

endpackage

// ===== rtl/psq_queue.sv =====
// ============================================================================
// psq_queue
// Message queue: handle and length memory with pointers and fill count.
// ============================================================================
module psq_queue
    import psq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4,
    parameter int unsigned PTR_W       = 2,
    parameter int unsigned CNT_W       = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  psq_qctl_t          ctl,
    input  logic [MSG_W-1:0]   msg_id,
    input  logic [TOPIC_W-1:0] topic_len,
    input  logic [LEN_W-1:0]   body_len,
    input  logic [TOPIC_W-1:0] topic_limit,
    input  logic [LEN_W-1:0]   payload_limit,
    output psq_qstat_t         stat,
    output logic [CNT_W-1:0]   fill_next,
    output logic [MSG_W-1:0]   rd_msg,
    output logic [LEN_W-1:0]   rd_len
);

    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_FILL = CNT_W'(QUEUE_DEPTH);

    logic [MSG_W+LEN_W-1:0] mem [QUEUE_DEPTH];
    logic [MSG_W+LEN_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       fill_reg;
    logic                   push;
    logic                   pop;

    assign push = ctl.enq_req && (body_len != '0) && (body_len < payload_limit)
                  && (topic_len < topic_limit) && (fill_reg < DEPTH_FILL);
    assign pop  = ctl.pop && (fill_reg != '0);

    assign stat.accepted = push;
    assign stat.empty    = (fill_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // A push and a pop never come in the same cycle, and a pop only reads an
    // entry written at an earlier edge, so the memory needs no bypass.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= {msg_id, body_len};
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_msg = rd_data_reg[MSG_W+LEN_W-1:LEN_W];
    assign rd_len = rd_data_reg[LEN_W-1:0];

`ifndef SYNTH
    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("queue push and pop in the same cycle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_FILL)
        else $error("queue fill count above depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (fill_reg == $past(fill_reg) + 1'b1) && (wr_ptr_reg != $past(wr_ptr_reg)
                  || QUEUE_DEPTH == 1))
        else $error("queue push did not advance fill and write pointer");
`endif

endmodule

// ===== rtl/psq_phase.sv =====
// ============================================================================
// psq_phase
// Publish phase machine with per-phase deadline and wrap-safe timeout test.
// ============================================================================
module psq_phase
    import psq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 poll,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic                 prompt_seen,
    input  logic                 send_done,
    input  logic                 ok_seen,
    input  logic                 error_seen,
    input  logic                 write_failed,
    input  logic                 queue_empty,
    input  logic [TIMEOUT_W-1:0] prompt_timeout_ms,
    input  logic [TIMEOUT_W-1:0] send_timeout_ms,
    input  logic [TIMEOUT_W-1:0] ok_timeout_ms,
    output logic                 pop,
    output action_t              action
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] deadline_next;
    logic [TIME_W-1:0] elapsed;
    logic              expired;

    assign elapsed = now_ms - deadline_reg;
    assign expired = !elapsed[TIME_W-1];

    always_comb
    begin
        phase_next    = phase_reg;
        deadline_next = deadline_reg;
        if (poll)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        phase_next    = PH_PROMPT;
                        deadline_next = now_ms + TIME_W'(prompt_timeout_ms);
                    end
                end
                PH_PROMPT:
                begin
                    if (prompt_seen)
                    begin
                        if (write_failed)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next    = PH_SENT;
                            deadline_next = now_ms + TIME_W'(send_timeout_ms);
                        end
                    end
                    else if (expired)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_SENT:
                begin
                    if (send_done)
                    begin
                        phase_next    = PH_OK;
                        deadline_next = now_ms + TIME_W'(ok_timeout_ms);
                    end
                    else if (expired)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_OK:
                begin
                    if (ok_seen || error_seen || expired)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        pop    = 1'b0;
        action = ACT_NONE;
        if (poll)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        pop    = 1'b1;
                        action = ACT_PUBLISH;
                    end
                end
                PH_PROMPT:
                begin
                    if (prompt_seen)
                    begin
                        action = write_failed ? ACT_WRITE_FAIL : ACT_WRITE_PAYLOAD;
                    end
                    else if (expired)
                    begin
                        action = ACT_PROMPT_TIMEOUT;
                    end
                end
                PH_SENT:
                begin
                    if (!send_done && expired)
                    begin
                        action = ACT_SEND_TIMEOUT;
                    end
                end
                PH_OK:
                begin
                    if (ok_seen)
                    begin
                        action = ACT_SUCCESS;
                    end
                    else if (error_seen || expired)
                    begin
                        action = ACT_ERROR;
                    end
                end
                default:
                begin
                    action = ACT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            deadline_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule

// ===== rtl/publish_request_sequencer_unit.sv =====
// ============================================================================
// publish_request_sequencer_unit
// Queues publish requests and sequences the prompt, send and OK phases.
// ============================================================================
//
//  Channel   Handshake             Payload
//  -------   -------------------   ----------------------------------------
//  input     in_valid / in_ready   cmd, msg_id, topic_len, body_len,
//                                  now_ms, prompt_seen, send_done, ok_seen,
//                                  error_seen, write_failed
//  output    out_valid / out_ready enqueue_accepted, action, active_msg,
//                                  active_len, queue_level
//  config    cfg_we                cfg_index, cfg_data
//
//  One word is accepted per cycle while the output is not stalled; its
//  result passes through stage s1 and then the output registers.
//  The registered read of the queue memory supplies the popped handle
//  and length in the stage after acceptance.
//  The reset clears all control state and needs no clearing pass.
//  A stalled output holds both stages and then drops in_ready.
//
module publish_request_sequencer_unit
    import psq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [MSG_W-1:0]     msg_id,
    input  logic [TOPIC_W-1:0]   topic_len,
    input  logic [LEN_W-1:0]     body_len,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic                 prompt_seen,
    input  logic                 send_done,
    input  logic                 ok_seen,
    input  logic                 error_seen,
    input  logic                 write_failed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 enqueue_accepted,
    output logic [2:0]           action,
    output logic [MSG_W-1:0]     active_msg,
    output logic [LEN_W-1:0]     active_len,
    output logic [LEVEL_W-1:0]   queue_level,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [TIMEOUT_W-1:0] prompt_timeout_reg;
    logic [TIMEOUT_W-1:0] send_timeout_reg;
    logic [TIMEOUT_W-1:0] ok_timeout_reg;
    logic [TOPIC_W-1:0]   topic_limit_reg;
    logic [LEN_W-1:0]     payload_limit_reg;

    logic                 fire;
    logic                 s1_move;
    psq_qctl_t            qctl;
    psq_qstat_t           qstat;
    logic [CNT_W-1:0]     fill_next;
    logic [CNT_W+2:0]     fill_ext;
    logic [MSG_W-1:0]     rd_msg;
    logic [LEN_W-1:0]     rd_len;
    logic                 pop;
    action_t              ph_action;

    logic                 s1_valid_reg;
    logic                 s1_accepted_reg;
    action_t              s1_action_reg;
    logic                 s1_pop_reg;
    logic [LEVEL_W-1:0]   s1_level_reg;

    logic                 out_valid_reg;
    logic                 out_accepted_reg;
    action_t              out_action_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    logic [MSG_W-1:0]     cur_msg_reg;
    logic [MSG_W-1:0]     cur_msg_next;
    logic [LEN_W-1:0]     cur_len_reg;
    logic [LEN_W-1:0]     cur_len_next;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign fire     = in_valid && in_ready;

    assign qctl.enq_req = fire && !cmd;
    assign qctl.pop     = pop;
    assign fill_ext     = {3'b000, fill_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prompt_timeout_reg <= PROMPT_TIMEOUT_RST;
            send_timeout_reg   <= SEND_TIMEOUT_RST;
            ok_timeout_reg     <= OK_TIMEOUT_RST;
            topic_limit_reg    <= TOPIC_LIMIT_RST;
            payload_limit_reg  <= PAYLOAD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROMPT_TIMEOUT: prompt_timeout_reg <= cfg_data;
                CFG_SEND_TIMEOUT:   send_timeout_reg   <= cfg_data;
                CFG_OK_TIMEOUT:     ok_timeout_reg     <= cfg_data;
                CFG_TOPIC_LIMIT:    topic_limit_reg    <= cfg_data[TOPIC_W-1:0];
                CFG_PAYLOAD_LIMIT:  payload_limit_reg  <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    psq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (qctl),
        .msg_id        (msg_id),
        .topic_len     (topic_len),
        .body_len      (body_len),
        .topic_limit   (topic_limit_reg),
        .payload_limit (payload_limit_reg),
        .stat          (qstat),
        .fill_next     (fill_next),
        .rd_msg        (rd_msg),
        .rd_len        (rd_len)
    );

    psq_phase u_phase (
        .clk               (clk),
        .rst_n             (rst_n),
        .poll              (fire && cmd),
        .now_ms            (now_ms),
        .prompt_seen       (prompt_seen),
        .send_done         (send_done),
        .ok_seen           (ok_seen),
        .error_seen        (error_seen),
        .write_failed      (write_failed),
        .queue_empty       (qstat.empty),
        .prompt_timeout_ms (prompt_timeout_reg),
        .send_timeout_ms   (send_timeout_reg),
        .ok_timeout_ms     (ok_timeout_reg),
        .pop               (pop),
        .action            (ph_action)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_accepted_reg <= qstat.accepted;
            s1_action_reg   <= ph_action;
            s1_pop_reg      <= pop;
            s1_level_reg    <= fill_ext[LEVEL_W-1:0];
        end
    end

    assign cur_msg_next = (s1_move && s1_pop_reg) ? rd_msg : cur_msg_reg;
    assign cur_len_next = (s1_move && s1_pop_reg) ? rd_len : cur_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_msg_reg   <= '0;
            cur_len_reg   <= '0;
        end
        else
        begin
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            cur_msg_reg <= cur_msg_next;
            cur_len_reg <= cur_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_accepted_reg <= s1_accepted_reg;
            out_action_reg   <= s1_action_reg;
            out_level_reg    <= s1_level_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign enqueue_accepted = out_accepted_reg;
    assign action           = out_action_reg;
    assign active_msg       = cur_msg_reg;
    assign active_len       = cur_len_reg;
    assign queue_level      = out_level_reg;

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while both stages are stalled");

    a_enqueue_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !cmd) |=> (s1_action_reg == ACT_NONE) && !s1_pop_reg)
        else $error("enqueue word produced a phase action");

    a_pop_means_publish: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pop) |-> (ph_action == ACT_PUBLISH) && !qstat.empty)
        else $error("pop without publish action or from an empty queue");
`endif

endmodule
